// File: src/esrt_pkg.sv
// ----------------------------------------------------------------------------
// esrt_pkg
// Shared types, constants and helper functions for the world matrix core.
// ----------------------------------------------------------------------------
package esrt_pkg;

  // internal datapath word: holds +/-2^32 and Q2.30 CORDIC values
  localparam int CW = 34;
  localparam int AW = 20;
  localparam int TABLE_LEN = 24;

  localparam logic signed [AW:0] ANG_PI      = 21'sd205887;
  localparam logic signed [AW:0] ANG_TWO_PI  = 21'sd411775;
  localparam logic signed [AW:0] ANG_HALF_PI = 21'sd102944;

  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

  typedef logic signed [CW-1:0] cval_t;

  typedef struct packed {
    cval_t c;
    cval_t s;
  } trig_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec32_t;

  // atan(2^-i) in Q2.30
  function automatic cval_t atan_q30(input int unsigned i);
    cval_t r;
    case (i)
      0:  r = 34'sd843314857;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043837;
      3:  r = 34'sd133525159;
      4:  r = 34'sd67021687;
      5:  r = 34'sd33543516;
      6:  r = 34'sd16775851;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194283;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048576;
      11: r = 34'sd524288;
      12: r = 34'sd262144;
      13: r = 34'sd131072;
      14: r = 34'sd65536;
      15: r = 34'sd32768;
      16: r = 34'sd16384;
      17: r = 34'sd8192;
      18: r = 34'sd4096;
      19: r = 34'sd2048;
      20: r = 34'sd1024;
      21: r = 34'sd512;
      22: r = 34'sd256;
      23: r = 34'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input cval_t v);
    logic signed [31:0] r;
    if (v > $signed({{(CW-32){1'b0}}, 32'h7fffffff})) begin
      r = 32'sh7fffffff;
    end else if (v < $signed({{(CW-32){1'b1}}, 32'h80000000})) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: src/esrt_cordic.sv
// ----------------------------------------------------------------------------
// esrt_cordic
// Pipelined rotation-mode CORDIC: one angle in, cosine and sine out (Q2.30).
// ----------------------------------------------------------------------------
module esrt_cordic #(
  parameter int STEPS = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [19:0]    angle,
  output esrt_pkg::trig_t       trig
);

  localparam int N = (STEPS < esrt_pkg::TABLE_LEN) ? STEPS : esrt_pkg::TABLE_LEN;

  logic signed [20:0] a_ext, a_wrap, a_half;
  logic               neg_c;

  esrt_pkg::cval_t x [N+1];
  esrt_pkg::cval_t y [N+1];
  esrt_pkg::cval_t z [N+1];
  logic            ng [N+1];

  // range reduction to [-pi/2, pi/2] with a sign flag
  always_comb begin
    a_ext = {angle[19], angle};
    if (a_ext > esrt_pkg::ANG_PI) begin
      a_wrap = a_ext - esrt_pkg::ANG_TWO_PI;
    end else if (a_ext < -esrt_pkg::ANG_PI) begin
      a_wrap = a_ext + esrt_pkg::ANG_TWO_PI;
    end else begin
      a_wrap = a_ext;
    end
    neg_c = 1'b0;
    a_half = a_wrap;
    if (a_wrap > esrt_pkg::ANG_HALF_PI) begin
      a_half = a_wrap - esrt_pkg::ANG_PI;
      neg_c  = 1'b1;
    end else if (a_wrap < -esrt_pkg::ANG_HALF_PI) begin
      a_half = a_wrap + esrt_pkg::ANG_PI;
      neg_c  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]  <= esrt_pkg::CORDIC_X0;
      y[0]  <= '0;
      // reduced angle fits in 20 bits; scale to Q2.30
      z[0]  <= {a_half[19:0], 14'd0};
      ng[0] <= neg_c;
      for (int i = 0; i < N; i++) begin
        if (!z[i][esrt_pkg::CW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - esrt_pkg::atan_q30(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + esrt_pkg::atan_q30(i);
        end
        ng[i+1] <= ng[i];
      end
      trig.c <= ng[N] ? -x[N] : x[N];
      trig.s <= ng[N] ? -y[N] : y[N];
    end
  end

endmodule

// File: src/esrt_rot.sv
// ----------------------------------------------------------------------------
// esrt_rot
// Three-stage plane rotation of a pair (p,q) by (cos,sin), clamped to +/-2^32.
// ----------------------------------------------------------------------------
module esrt_rot (
  input  logic             clk,
  input  logic             en,
  input  esrt_pkg::cval_t  p,
  input  esrt_pkg::cval_t  q,
  input  esrt_pkg::trig_t  t,
  output esrt_pkg::cval_t  p_out,
  output esrt_pkg::cval_t  q_out
);

  localparam logic signed [38:0] LIM = 39'sd4294967296;

  // operand halves: signed high 17 bits, unsigned low 17 bits
  logic signed [50:0] hh [4];
  logic signed [51:0] ll [4];
  logic signed [37:0] m  [4];
  logic signed [38:0] np, nq;
  logic signed [67:0] full [4];

  function automatic esrt_pkg::cval_t clamp_lim(input logic signed [38:0] v);
    esrt_pkg::cval_t r;
    if (v > LIM) begin
      r = LIM[33:0];
    end else if (v < -LIM) begin
      r = -$signed(LIM[33:0]);
    end else begin
      r = v[33:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      hh[0] <= $signed(p[33:17]) * t.c;
      ll[0] <= $signed({1'b0, p[16:0]}) * t.c;
      hh[1] <= $signed(q[33:17]) * t.s;
      ll[1] <= $signed({1'b0, q[16:0]}) * t.s;
      hh[2] <= $signed(p[33:17]) * t.s;
      ll[2] <= $signed({1'b0, p[16:0]}) * t.s;
      hh[3] <= $signed(q[33:17]) * t.c;
      ll[3] <= $signed({1'b0, q[16:0]}) * t.c;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      full[k] = ({{17{hh[k][50]}}, hh[k]} <<< 17) + {{16{ll[k][51]}}, ll[k]};
    end
  end

  // floor(v*t / 2^30) is the upper slice of the full product
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        m[k] <= full[k][67:30];
      end
    end
  end

  assign np = {m[0][37], m[0]} - {m[1][37], m[1]};
  assign nq = {m[2][37], m[2]} + {m[3][37], m[3]};

  always_ff @(posedge clk) begin
    if (en) begin
      p_out <= clamp_lim(np);
      q_out <= clamp_lim(nq);
    end
  end

endmodule

// File: src/esrt_row.sv
// ----------------------------------------------------------------------------
// esrt_row
// One matrix row lane: rotate about X, then Y, then Z.
// ty must arrive with the X rotation results and tz with the Y rotation results for the same request.
// ----------------------------------------------------------------------------
module esrt_row (
  input  logic             clk,
  input  logic             en,
  input  esrt_pkg::cval_t  vx,
  input  esrt_pkg::cval_t  vy,
  input  esrt_pkg::cval_t  vz,
  input  esrt_pkg::trig_t  tx,
  input  esrt_pkg::trig_t  ty,
  input  esrt_pkg::trig_t  tz,
  output esrt_pkg::cval_t  ox,
  output esrt_pkg::cval_t  oy,
  output esrt_pkg::cval_t  oz
);

  esrt_pkg::cval_t x_d [3];
  esrt_pkg::cval_t y_d [3];
  esrt_pkg::cval_t z_d [3];
  esrt_pkg::cval_t y1, z1, x2, z2;
  esrt_pkg::trig_t ty_n;

  // Y rotation uses the negated sine
  assign ty_n.c = ty.c;
  assign ty_n.s = -ty.s;

  esrt_rot u_rot_x (
    .clk(clk), .en(en), .p(vy), .q(vz), .t(tx), .p_out(y1), .q_out(z1)
  );

  esrt_rot u_rot_y (
    .clk(clk), .en(en), .p(x_d[2]), .q(z1), .t(ty_n), .p_out(x2), .q_out(z2)
  );

  esrt_rot u_rot_z (
    .clk(clk), .en(en), .p(x2), .q(y_d[2]), .t(tz), .p_out(ox), .q_out(oy)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      x_d[0] <= vx;
      y_d[0] <= y1;
      z_d[0] <= z2;
      for (int k = 1; k < 3; k++) begin
        x_d[k] <= x_d[k-1];
        y_d[k] <= y_d[k-1];
        z_d[k] <= z_d[k-1];
      end
    end
  end

  assign oz = z_d[2];

endmodule

// File: src/euler_srt_world_matrix_core.sv
// ----------------------------------------------------------------------------
// euler_srt_world_matrix_core
// Scale / Euler XYZ rotate / translate world matrix, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Accepts one request per clock unless the output is stalled, and returns one
// matrix per request in order. It is built from a CORDIC pipeline of one stage
// per iteration plus reduction and sign stages, three 3-stage rotation units
// per row lane (one per axis, three row lanes side by side), and an output
// saturation register. When out_stall holds the output, the whole pipeline
// freezes and in_stall is raised in the same cycle.
module euler_srt_world_matrix_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] scale_x,
  input  logic signed [31:0] scale_y,
  input  logic signed [31:0] scale_z,
  input  logic signed [19:0] angle_x,
  input  logic signed [19:0] angle_y,
  input  logic signed [19:0] angle_z,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] right_x,
  output logic signed [31:0] right_y,
  output logic signed [31:0] right_z,
  output logic signed [31:0] up_x,
  output logic signed [31:0] up_y,
  output logic signed [31:0] up_z,
  output logic signed [31:0] look_x,
  output logic signed [31:0] look_y,
  output logic signed [31:0] look_z,
  output logic signed [31:0] trans_x,
  output logic signed [31:0] trans_y,
  output logic signed [31:0] trans_z
);

  localparam int N   = (CORDIC_STEPS < esrt_pkg::TABLE_LEN) ?
                       CORDIC_STEPS : esrt_pkg::TABLE_LEN;
  localparam int L   = N + 2;   // CORDIC latency
  localparam int LAT = L + 10;  // full latency

  logic adv;
  logic [LAT-1:0] vpipe;

  esrt_pkg::trig_t tx, ty, tz;
  esrt_pkg::trig_t ty_d [3];
  esrt_pkg::trig_t tz_d [6];
  esrt_pkg::vec32_t sc_d  [L];
  esrt_pkg::vec32_t pos_d [L+9];
  esrt_pkg::cval_t  rx [3];
  esrt_pkg::cval_t  ry [3];
  esrt_pkg::cval_t  rz [3];
  esrt_pkg::cval_t  zero_c;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign zero_c   = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (adv) begin
      vpipe <= {vpipe[LAT-2:0], in_valid};
    end
  end

  assign out_valid = vpipe[LAT-1];

  esrt_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_x (
    .clk(clk), .en(adv), .angle(angle_x), .trig(tx)
  );
  esrt_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_y (
    .clk(clk), .en(adv), .angle(angle_y), .trig(ty)
  );
  esrt_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_z (
    .clk(clk), .en(adv), .angle(angle_z), .trig(tz)
  );

  // align scale, position and the later-axis trig values with the lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      sc_d[0]  <= '{x: scale_x, y: scale_y, z: scale_z};
      pos_d[0] <= '{x: pos_x, y: pos_y, z: pos_z};
      for (int k = 1; k < L; k++) begin
        sc_d[k] <= sc_d[k-1];
      end
      for (int k = 1; k < L + 9; k++) begin
        pos_d[k] <= pos_d[k-1];
      end
      ty_d[0] <= ty;
      for (int k = 1; k < 3; k++) begin
        ty_d[k] <= ty_d[k-1];
      end
      tz_d[0] <= tz;
      for (int k = 1; k < 6; k++) begin
        tz_d[k] <= tz_d[k-1];
      end
    end
  end

  esrt_row u_row_right (
    .clk(clk), .en(adv),
    .vx({{2{sc_d[L-1].x[31]}}, sc_d[L-1].x}), .vy(zero_c), .vz(zero_c),
    .tx(tx), .ty(ty_d[2]), .tz(tz_d[5]),
    .ox(rx[0]), .oy(ry[0]), .oz(rz[0])
  );

  esrt_row u_row_up (
    .clk(clk), .en(adv),
    .vx(zero_c), .vy({{2{sc_d[L-1].y[31]}}, sc_d[L-1].y}), .vz(zero_c),
    .tx(tx), .ty(ty_d[2]), .tz(tz_d[5]),
    .ox(rx[1]), .oy(ry[1]), .oz(rz[1])
  );

  esrt_row u_row_look (
    .clk(clk), .en(adv),
    .vx(zero_c), .vy(zero_c), .vz({{2{sc_d[L-1].z[31]}}, sc_d[L-1].z}),
    .tx(tx), .ty(ty_d[2]), .tz(tz_d[5]),
    .ox(rx[2]), .oy(ry[2]), .oz(rz[2])
  );

  // merge stage: saturate row lanes, attach position
  always_ff @(posedge clk) begin
    if (adv) begin
      right_x <= esrt_pkg::sat32(rx[0]);
      right_y <= esrt_pkg::sat32(ry[0]);
      right_z <= esrt_pkg::sat32(rz[0]);
      up_x    <= esrt_pkg::sat32(rx[1]);
      up_y    <= esrt_pkg::sat32(ry[1]);
      up_z    <= esrt_pkg::sat32(rz[1]);
      look_x  <= esrt_pkg::sat32(rx[2]);
      look_y  <= esrt_pkg::sat32(ry[2]);
      look_z  <= esrt_pkg::sat32(rz[2]);
      trans_x <= pos_d[L+8].x;
      trans_y <= pos_d[L+8].y;
      trans_z <= pos_d[L+8].z;
    end
  end

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vpipe[0])
    else $error("accepted request did not enter pipeline");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vpipe[LAT-2]))
    else $error("output valid without a request in flight");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(vpipe))
    else $error("pipeline moved while output stalled");

endmodule
